// File: rtl/core/mrrpm_pkg.sv
// Shared widths, codes, types and helpers of the ring pointer manager.
`default_nettype none
package mrrpm_pkg;

   localparam int POS_W  = 17;
   localparam int LEN_W  = 17;
   localparam int OFF_W  = 16;
   localparam int KIND_W = 3;
   localparam int ID_W   = 3;
   localparam int CNT_W  = 4;
   localparam int TOT_W  = 64;
   localparam int FULL_W = 32;
   localparam int HIT_W  = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;

   localparam logic [KIND_W-1:0] KIND_WR_QUERY   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WR_ADVANCE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RD_QUERY   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RD_ADVANCE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RD_START   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READER_COUNT = 4'd1;

   localparam logic [LEN_W-1:0] LOW_WATER_RESET = 17'd65536;
   localparam logic [POS_W-1:0] SIZE_MIN        = 17'd2;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [HIT_W-1:0] hit_type;

   typedef struct packed {
      logic start;
      logic sample;
   } wq_ctrl_type;

   typedef struct packed {
      len_type run;
      len_type low_free;
      hit_type hits;
   } wq_result_type;

   // Moves a position forward; a landing point past the last index wraps to zero.
   function automatic pos_type mrrpm_advance(input pos_type pos, input len_type len,
                                             input pos_type size);
      logic [POS_W:0] sum;
      pos_type result;
      sum = {1'b0, pos} + {1'b0, len};
      if (sum >= {1'b0, size}) begin
         result = '0;
      end else begin
         result = sum[POS_W-1:0];
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/mrrpm_wq_unit.sv
// Accumulator that folds reader pointers into the free run of a writer query.
`default_nettype none
module mrrpm_wq_unit (
   input  logic                        clock,
   input  mrrpm_pkg::wq_ctrl_type      ctrl,
   input  mrrpm_pkg::pos_type          rd_pos,
   input  mrrpm_pkg::pos_type          writer_pos,
   input  mrrpm_pkg::pos_type          size,
   output mrrpm_pkg::wq_result_type    result
);
   import mrrpm_pkg::*;

   len_type        run_ff, run_in;
   len_type        low_ff, low_in;
   hit_type        hits_ff, hits_in;
   logic [POS_W:0] wp_inc;
   logic           is_full;
   len_type        run_d;
   len_type        free_d;

   always_comb begin
      wp_inc  = {1'b0, writer_pos} + 1'b1;
      is_full = ({1'b0, rd_pos} == wp_inc);
      if (is_full) begin
         run_d = '0;
      end else if (writer_pos >= rd_pos) begin
         run_d = size - writer_pos;
      end else begin
         run_d = rd_pos - writer_pos - 1'b1;
      end
      if (rd_pos > writer_pos) begin
         free_d = rd_pos - writer_pos - 1'b1;
      end else begin
         free_d = size - (writer_pos - rd_pos);
      end

      run_in  = run_ff;
      low_in  = low_ff;
      hits_in = hits_ff;
      if (ctrl.start) begin
         run_in  = size;
         low_in  = size;
         hits_in = '0;
      end else if (ctrl.sample) begin
         if (run_d <= run_ff) begin
            run_in = run_d;
         end
         if (free_d < low_ff) begin
            low_in = free_d;
         end
         hits_in = hits_ff + hit_type'(is_full);
      end
   end

   always_ff @(posedge clock) begin
      run_ff  <= run_in;
      low_ff  <= low_in;
      hits_ff <= hits_in;
   end

   assign result.run      = run_ff;
   assign result.low_free = low_ff;
   assign result.hits     = hits_ff;

endmodule
`default_nettype wire

// File: rtl/core/multi_reader_ring_pointer_manager.sv
// Top level of the single-writer, multi-reader ring buffer pointer manager.
// One request is handled at a time. A writer query reads every reader pointer
// from the pointer memory, one per cycle, and then passes through the end and
// finish states before the next request can be accepted; reader queries and
// reader advances with a valid reader id need one memory read; all other
// requests pass through the execute and finish states. A write to buffer_size
// starts a pass over the pointer memory that clamps stale reader positions;
// no request is accepted while it runs. A finished result waits in the output
// register while the next request is accepted.
`default_nettype none
module multi_reader_ring_pointer_manager #(
   parameter int MAX_SIZE = 65536,
   parameter int READERS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mrrpm_pkg::KIND_W-1:0]         req_kind,
   input  logic [mrrpm_pkg::ID_W-1:0]           req_reader_id,
   input  logic [mrrpm_pkg::LEN_W-1:0]          req_advance_len,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mrrpm_pkg::OFF_W-1:0]          rsp_offset,
   output logic [mrrpm_pkg::LEN_W-1:0]          rsp_length,
   output logic [mrrpm_pkg::TOT_W-1:0]          rsp_bytes_written,
   output logic [mrrpm_pkg::FULL_W-1:0]         rsp_full_events,
   output logic [mrrpm_pkg::LEN_W-1:0]          rsp_min_free,
   output logic                                 rsp_all_ready,
   input  logic                                 csr_write_enable,
   input  logic [mrrpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mrrpm_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import mrrpm_pkg::*;

   localparam int IDX_W  = (READERS > 1) ? $clog2(READERS) : 1;
   localparam int SCAN_W = $clog2(READERS + 1);
   localparam int STW    = $clog2(READERS + 1);
   localparam int CAP    = (MAX_SIZE > 131071) ? 131071 : MAX_SIZE;
   localparam int RST_SZ = (MAX_SIZE < 65536) ? MAX_SIZE : 65536;
   localparam logic [POS_W-1:0] SizeCap   = POS_W'(CAP);
   localparam logic [POS_W-1:0] SizeReset = POS_W'(RST_SZ);
   localparam logic [SCAN_W-1:0] ScanEnd  = SCAN_W'(READERS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_WQEND  = 3'd2;
   localparam logic [2:0] ST_RDOP   = 3'd3;
   localparam logic [2:0] ST_EXEC   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   len_type             len_ff, len_in;
   logic                id_ok_ff, id_ok_in;

   pos_type             writer_pos_ff, writer_pos_in;
   logic [TOT_W-1:0]    byte_total_ff, byte_total_in;
   logic [FULL_W-1:0]   full_total_ff, full_total_in;
   len_type             low_water_ff, low_water_in;
   logic [READERS-1:0]  active_ff, active_in;
   logic [STW-1:0]      started_ff, started_in;
   pos_type             size_ff, size_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   pos_type             res_off_ff, res_off_in;
   len_type             res_len_ff, res_len_in;

   logic [SCAN_W-1:0]   issue_ff, issue_in;
   logic                samp_ff, samp_in;

   logic                sw_pend_ff, sw_pend_in;
   logic [SCAN_W-1:0]   sw_idx_ff, sw_idx_in;
   logic                sw_wb_ff, sw_wb_in;
   logic [IDX_W-1:0]    sw_wb_idx_ff, sw_wb_idx_in;
   pos_type             sw_thr_ff, sw_thr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]    rsp_offset_ff, rsp_offset_in;
   len_type             rsp_length_ff, rsp_length_in;
   logic [TOT_W-1:0]    rsp_bytes_ff, rsp_bytes_in;
   logic [FULL_W-1:0]   rsp_full_ff, rsp_full_in;
   len_type             rsp_min_free_ff, rsp_min_free_in;
   logic                rsp_ready_ff, rsp_ready_in;

   pos_type             pos_mem [READERS];
   pos_type             mem_rdata_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [IDX_W-1:0]    mem_raddr;
   pos_type             mem_wdata;

   logic                accept;
   logic                req_id_ok;
   logic [IDX_W-1:0]    id_idx;
   pos_type             adv_pos;
   pos_type             new_size;
   wq_ctrl_type         wq_ctrl;
   wq_result_type       wq_res;

   mrrpm_wq_unit u_wq_unit (
      .clock      (clock),
      .ctrl       (wq_ctrl),
      .rd_pos     (mem_rdata_ff),
      .writer_pos (writer_pos_ff),
      .size       (size_ff),
      .result     (wq_res)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= pos_mem[mem_raddr];
   end

   assign req_stall = (state_ff != ST_IDLE) || sw_pend_ff || csr_write_enable;
   assign accept    = req_valid && !req_stall;
   assign req_id_ok = 32'(req_reader_id) < READERS;
   assign id_idx    = IDX_W'(id_ff);

   always_comb begin
      new_size = csr_write_data[POS_W-1:0];
      if (new_size < SIZE_MIN) begin
         new_size = SIZE_MIN;
      end else if (new_size > SizeCap) begin
         new_size = SizeCap;
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      len_in        = len_ff;
      id_ok_in      = id_ok_ff;
      writer_pos_in = writer_pos_ff;
      byte_total_in = byte_total_ff;
      full_total_in = full_total_ff;
      low_water_in  = low_water_ff;
      active_in     = active_ff;
      started_in    = started_ff;
      size_in       = size_ff;
      count_in      = count_ff;
      res_off_in    = res_off_ff;
      res_len_in    = res_len_ff;
      issue_in      = issue_ff;
      samp_in       = samp_ff;
      sw_pend_in    = sw_pend_ff;
      sw_idx_in     = sw_idx_ff;
      sw_wb_in      = 1'b0;
      sw_wb_idx_in  = sw_wb_idx_ff;
      sw_thr_in     = sw_thr_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_bytes_in    = rsp_bytes_ff;
      rsp_full_in     = rsp_full_ff;
      rsp_min_free_in = rsp_min_free_ff;
      rsp_ready_in    = rsp_ready_ff;
      mem_we        = 1'b0;
      mem_waddr     = id_idx;
      mem_wdata     = '0;
      mem_raddr     = IDX_W'(req_reader_id);
      wq_ctrl       = '0;
      adv_pos       = mrrpm_advance(writer_pos_ff, len_ff, size_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               id_in    = req_reader_id;
               len_in   = req_advance_len;
               id_ok_in = req_id_ok;
               case (req_kind)
                  KIND_WR_QUERY: begin
                     wq_ctrl.start = 1'b1;
                     issue_in      = '0;
                     samp_in       = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  KIND_RD_QUERY, KIND_RD_ADVANCE: begin
                     state_in = req_id_ok ? ST_RDOP : ST_EXEC;
                  end
                  default: begin
                     state_in = ST_EXEC;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_raddr      = IDX_W'(issue_ff);
            wq_ctrl.sample = samp_ff;
            if (issue_ff == ScanEnd) begin
               samp_in  = 1'b0;
               state_in = ST_WQEND;
            end else begin
               samp_in  = active_ff[IDX_W'(issue_ff)];
               issue_in = issue_ff + 1'b1;
            end
         end
         ST_WQEND: begin
            full_total_in = full_total_ff + FULL_W'(wq_res.hits)
                          + FULL_W'(wq_res.run == '0);
            if ((wq_res.run < low_water_ff) && (wq_res.low_free < low_water_ff)) begin
               low_water_in = wq_res.low_free;
            end
            res_off_in = writer_pos_ff;
            res_len_in = wq_res.run;
            state_in   = ST_FINISH;
         end
         ST_RDOP: begin
            res_len_in = '0;
            if (kind_ff == KIND_RD_QUERY) begin
               if (writer_pos_ff > mem_rdata_ff) begin
                  res_len_in = writer_pos_ff - mem_rdata_ff;
               end else if (mem_rdata_ff > writer_pos_ff) begin
                  res_len_in = size_ff - mem_rdata_ff;
               end
               res_off_in = mem_rdata_ff;
            end else begin
               adv_pos    = mrrpm_advance(mem_rdata_ff, len_ff, size_ff);
               mem_we     = 1'b1;
               mem_wdata  = adv_pos;
               res_off_in = adv_pos;
            end
            state_in = ST_FINISH;
         end
         ST_EXEC: begin
            res_len_in = '0;
            case (kind_ff)
               KIND_WR_ADVANCE: begin
                  byte_total_in = byte_total_ff + TOT_W'(len_ff);
                  writer_pos_in = adv_pos;
                  res_off_in    = adv_pos;
               end
               KIND_RD_START: begin
                  if (id_ok_ff) begin
                     mem_we            = 1'b1;
                     mem_wdata         = '0;
                     active_in[id_idx] = 1'b1;
                     if (!active_ff[id_idx]) begin
                        started_in = started_ff + 1'b1;
                     end
                  end
                  res_off_in = '0;
               end
               KIND_RD_QUERY, KIND_RD_ADVANCE: begin
                  res_off_in = '0;
               end
               default: begin
                  res_off_in = writer_pos_ff;
               end
            endcase
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_offset_in   = res_off_ff[OFF_W-1:0];
               rsp_length_in   = res_len_ff;
               rsp_bytes_in    = byte_total_ff;
               rsp_full_in     = full_total_ff;
               rsp_min_free_in = low_water_ff;
               rsp_ready_in    = (32'(started_ff) == 32'(count_ff));
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Clamping pass over the reader pointers after a size change.
      if (sw_pend_ff) begin
         if (sw_idx_ff != ScanEnd) begin
            mem_raddr    = IDX_W'(sw_idx_ff);
            sw_wb_in     = 1'b1;
            sw_wb_idx_in = IDX_W'(sw_idx_ff);
            sw_idx_in    = sw_idx_ff + 1'b1;
         end else begin
            sw_pend_in = 1'b0;
         end
      end
      if (sw_wb_ff) begin
         mem_we    = 1'b1;
         mem_waddr = sw_wb_idx_ff;
         mem_wdata = (mem_rdata_ff >= sw_thr_ff) ? '0 : mem_rdata_ff;
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_BUFFER_SIZE: begin
               size_in = new_size;
               if (writer_pos_ff >= new_size) begin
                  writer_pos_in = '0;
               end
               sw_thr_in  = (sw_pend_ff && (sw_thr_ff < new_size)) ? sw_thr_ff : new_size;
               sw_pend_in = 1'b1;
               sw_idx_in  = '0;
            end
            CSR_READER_COUNT: begin
               count_in = csr_write_data[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         writer_pos_ff <= '0;
         byte_total_ff <= '0;
         full_total_ff <= '0;
         low_water_ff  <= LOW_WATER_RESET;
         active_ff     <= '0;
         started_ff    <= '0;
         size_ff       <= SizeReset;
         count_ff      <= CNT_W'(1);
         issue_ff      <= '0;
         samp_ff       <= 1'b0;
         sw_pend_ff    <= 1'b0;
         sw_idx_ff     <= '0;
         sw_wb_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         writer_pos_ff <= writer_pos_in;
         byte_total_ff <= byte_total_in;
         full_total_ff <= full_total_in;
         low_water_ff  <= low_water_in;
         active_ff     <= active_in;
         started_ff    <= started_in;
         size_ff       <= size_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         samp_ff       <= samp_in;
         sw_pend_ff    <= sw_pend_in;
         sw_idx_ff     <= sw_idx_in;
         sw_wb_ff      <= sw_wb_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      id_ff           <= id_in;
      len_ff          <= len_in;
      id_ok_ff        <= id_ok_in;
      res_off_ff      <= res_off_in;
      res_len_ff      <= res_len_in;
      sw_wb_idx_ff    <= sw_wb_idx_in;
      sw_thr_ff       <= sw_thr_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_bytes_ff    <= rsp_bytes_in;
      rsp_full_ff     <= rsp_full_in;
      rsp_min_free_ff <= rsp_min_free_in;
      rsp_ready_ff    <= rsp_ready_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_offset        = rsp_offset_ff;
   assign rsp_length        = rsp_length_ff;
   assign rsp_bytes_written = rsp_bytes_ff;
   assign rsp_full_events   = rsp_full_ff;
   assign rsp_min_free      = rsp_min_free_ff;
   assign rsp_all_ready     = rsp_ready_ff;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench of the ring pointer manager, driven by directed and random requests.
module tb_top;
   import mrrpm_pkg::*;

   localparam int NUM_READERS = 8;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 62;
   localparam int STUCK_LIMIT = 2000;
   localparam int SETTLE_CYCLES = NUM_READERS + 4;
   localparam int unsigned RING_MAX = 65536;
   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP = 4'hF;
   localparam logic [LEN_W-1:0] LEN_TOP = '1;

   typedef struct {
      logic [OFF_W-1:0] offset;
      logic [LEN_W-1:0] length;
      logic [TOT_W-1:0] bytes_written;
      logic [FULL_W-1:0] full_events;
      logic [LEN_W-1:0] min_free;
      logic all_ready;
   } ring_reply_type;

   class ring_ledger_type;
      int unsigned size = RING_MAX;
      int unsigned readers_wanted = 1;
      int unsigned wr_pos;
      int unsigned rd_pos[NUM_READERS];
      bit rd_on[NUM_READERS];
      longint unsigned byte_total;
      int unsigned full_total;
      int unsigned low_free = RING_MAX;
      ring_reply_type replies_due[$];
      int requests;
      int replies;
      int full_queries;
      int failures;

      function int unsigned step_pos(int unsigned pos, longint unsigned len);
         longint unsigned landing;
         landing = 64'(pos) + len;
         if (landing > 64'(size - 1)) begin
            return 0;
         end
         return landing[31:0];
      endfunction

      function int unsigned free_run(output int unsigned hits);
         int unsigned run;
         int unsigned d;
         int unsigned r;
         run = size;
         hits = 0;
         for (int i = 0; i < NUM_READERS; i++) begin
            if (rd_on[i]) begin
               r = rd_pos[i];
               if (r == wr_pos + 1) begin
                  hits++;
                  d = 0;
               end else if (wr_pos >= r) begin
                  d = size - wr_pos;
               end else begin
                  d = r - wr_pos - 1;
               end
               if (d <= run) begin
                  run = d;
               end
            end
         end
         return run;
      endfunction

      function int unsigned total_free();
         int unsigned least;
         int unsigned d;
         least = size;
         for (int i = 0; i < NUM_READERS; i++) begin
            if (rd_on[i]) begin
               if (rd_pos[i] > wr_pos) begin
                  d = rd_pos[i] - wr_pos - 1;
               end else begin
                  d = size - (wr_pos - rd_pos[i]);
               end
               if (d < least) begin
                  least = d;
               end
            end
         end
         return least;
      endfunction

      function int unsigned readable_run(int unsigned id);
         if (wr_pos > rd_pos[id]) begin
            return wr_pos - rd_pos[id];
         end
         if (rd_pos[id] > wr_pos) begin
            return size - rd_pos[id];
         end
         return 0;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                 logic [LEN_W-1:0] len);
         ring_reply_type want;
         int unsigned offset;
         int unsigned length;
         int unsigned hits;
         int unsigned started;
         offset = wr_pos;
         length = 0;
         started = 0;
         case (kind)
            KIND_WR_QUERY: begin
               length = free_run(hits);
               full_total += hits;
               if (length == 0) begin
                  full_total++;
                  full_queries++;
               end
               if (length < low_free && total_free() < low_free) begin
                  low_free = total_free();
               end
               offset = wr_pos;
            end
            KIND_WR_ADVANCE: begin
               byte_total += 64'(len);
               wr_pos = step_pos(wr_pos, 64'(len));
               offset = wr_pos;
            end
            KIND_RD_QUERY: begin
               length = readable_run(id);
               offset = rd_pos[id];
            end
            KIND_RD_ADVANCE: begin
               rd_pos[id] = step_pos(rd_pos[id], 64'(len));
               offset = rd_pos[id];
            end
            KIND_RD_START: begin
               rd_pos[id] = 0;
               rd_on[id] = 1'b1;
               offset = 0;
            end
            default: ;
         endcase
         foreach (rd_on[i]) begin
            started += 32'(rd_on[i]);
         end
         want.offset = offset[OFF_W-1:0];
         want.length = length[LEN_W-1:0];
         want.bytes_written = byte_total;
         want.full_events = full_total;
         want.min_free = low_free[LEN_W-1:0];
         want.all_ready = (started == readers_wanted);
         replies_due.push_back(want);
         requests++;
      endfunction

      function void apply_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_BUFFER_SIZE) begin
            size = 32'(data);
            if (size < 32'(SIZE_MIN)) begin
               size = 32'(SIZE_MIN);
            end
            if (size > RING_MAX) begin
               size = RING_MAX;
            end
            if (wr_pos > size - 1) begin
               wr_pos = 0;
            end
            foreach (rd_pos[i]) begin
               if (rd_pos[i] > size - 1) begin
                  rd_pos[i] = 0;
               end
            end
         end else if (index == CSR_READER_COUNT) begin
            readers_wanted = 32'(data[CNT_W-1:0]);
         end
      endfunction

      function void compare_field(string name, logic [TOT_W-1:0] want, logic [TOT_W-1:0] got);
         if (want !== got) begin
            failures++;
            if (failures <= 10) begin
               $display("reply %0d, %s: expected %0h, got %0h", replies, name, want, got);
            end
         end
      endfunction

      function void check_reply(ring_reply_type got);
         ring_reply_type want;
         replies++;
         if (replies_due.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("reply %0d arrived with no request outstanding", replies);
            end
            return;
         end
         want = replies_due.pop_front();
         compare_field("offset", 64'(want.offset), 64'(got.offset));
         compare_field("length", 64'(want.length), 64'(got.length));
         compare_field("bytes_written", want.bytes_written, got.bytes_written);
         compare_field("full_events", 64'(want.full_events), 64'(got.full_events));
         compare_field("min_free", 64'(want.min_free), 64'(got.min_free));
         compare_field("all_ready", 64'(want.all_ready), 64'(got.all_ready));
      endfunction

      function int pending();
         return replies_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = KIND_WR_QUERY;
   logic [ID_W-1:0] req_reader_id = '0;
   logic [LEN_W-1:0] req_advance_len = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OFF_W-1:0] rsp_offset;
   logic [LEN_W-1:0] rsp_length;
   logic [TOT_W-1:0] rsp_bytes_written;
   logic [FULL_W-1:0] rsp_full_events;
   logic [LEN_W-1:0] rsp_min_free;
   logic rsp_all_ready;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BUFFER_SIZE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int send_idle = 21;
   int recv_idle = 70;
   int stuck_cycles = 0;
   int unsigned phase_sizes[PHASES] = '{2, 0, 3, 1, 131071, 65536, 5, 17, 65535, 2, 40, 7};
   int unsigned phase_counts[PHASES] = '{1, 0, 8, 15, 3, 2, 4, 8, 1, 6, 5, 2};
   ring_ledger_type ledger;

   multi_reader_ring_pointer_manager uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.check_reply(ring_reply_type'{rsp_offset, rsp_length, rsp_bytes_written,
                                             rsp_full_events, rsp_min_free, rsp_all_ready});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
      begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no progress for %0d cycles", STUCK_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic [LEN_W-1:0] len);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_reader_id <= id;
      req_advance_len <= len;
      do @(posedge clock); while (req_stall);
      ledger.note_request(kind, id, len);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ledger.apply_register(index, data);
   endtask

   function automatic logic [LEN_W-1:0] pick_length(input int unsigned run,
                                                    input logic [LEN_W-1:0] noise);
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 4) begin
         return LEN_W'(run);
      end
      if (roll < 8) begin
         return LEN_W'($urandom_range(run));
      end
      return noise;
   endfunction

   task automatic random_request();
      int unsigned pick;
      int unsigned hits;
      int unsigned id;
      int unsigned started[$];
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0] len;
      for (int i = 0; i < NUM_READERS; i++) begin
         if (ledger.rd_on[i]) begin
            started.push_back(i);
         end
      end
      pick = $urandom_range(99);
      id = $urandom_range(NUM_READERS - 1);
      len = LEN_W'($urandom_range(LEN_TOP));
      if (pick >= 48 && pick < 84 && started.size() == 0) begin
         pick = 84;
      end
      if (pick < 30) begin
         kind = KIND_WR_QUERY;
      end else if (pick < 48) begin
         kind = KIND_WR_ADVANCE;
         len = pick_length(ledger.free_run(hits), len);
      end else if (pick < 66) begin
         kind = KIND_RD_QUERY;
         id = started[$urandom_range(started.size() - 1)];
      end else if (pick < 84) begin
         kind = KIND_RD_ADVANCE;
         id = started[$urandom_range(started.size() - 1)];
         len = pick_length(ledger.readable_run(id), len);
      end else if (pick < 94) begin
         kind = KIND_RD_START;
      end else begin
         kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      end
      send_request(kind, ID_W'(id), len);
   endtask

   initial begin
      ledger = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // With no reader expected and none started, the ring reports itself ready.
      write_register(CSR_READER_COUNT, '0);
      send_request(KIND_WR_QUERY, '0, '0);
      send_request(KIND_SPARE_FIRST, ID_W'(NUM_READERS - 1), LEN_TOP);
      drain();
      write_register(CSR_READER_COUNT, CSR_DATA_W'(1));

      send_request(KIND_RD_START, '0, '0);
      send_request(KIND_RD_START, ID_W'(NUM_READERS - 1), '0);
      send_request(KIND_WR_QUERY, '0, '0);
      send_request(KIND_WR_ADVANCE, '0, LEN_W'(RING_MAX - 1));
      send_request(KIND_WR_QUERY, '0, '0);
      send_request(KIND_RD_QUERY, '0, '0);
      send_request(KIND_RD_ADVANCE, ID_W'(NUM_READERS - 1), LEN_W'(RING_MAX));
      send_request(KIND_RD_ADVANCE, '0, LEN_W'(RING_MAX - 1));
      send_request(KIND_RD_QUERY, '0, '0);
      send_request(KIND_WR_ADVANCE, '0, LEN_W'(1));
      send_request(KIND_RD_ADVANCE, ID_W'(NUM_READERS - 1), LEN_W'(1));
      send_request(KIND_WR_QUERY, '0, '0);
      send_request(KIND_RD_QUERY, ID_W'(NUM_READERS - 1), '0);
      send_request(KIND_RD_QUERY, '0, '0);
      send_request(KIND_WR_ADVANCE, '0, LEN_TOP);
      send_request(KIND_W'(KIND_SPARE_FIRST + 1), '0, '0);
      send_request(KIND_SPARE_LAST, ID_W'(3), LEN_W'(RING_MAX));
      send_request(KIND_RD_START, ID_W'(3), '0);
      send_request(KIND_RD_ADVANCE, ID_W'(3), '0);
      send_request(KIND_WR_QUERY, '0, '0);
      send_request(KIND_RD_ADVANCE, '0, LEN_TOP);
      send_request(KIND_WR_ADVANCE, '0, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         send_idle = (phase < 4) ? 21 : ((phase < 8) ? 70 : 0);
         recv_idle = (phase < 4) ? 70 : ((phase < 8) ? 21 : 0);
         write_register(CSR_IDX_W'($urandom_range(CSR_READER_COUNT + 1, CSR_IDX_TOP)),
                        CSR_DATA_W'($urandom_range(LEN_TOP)));
         write_register(CSR_READER_COUNT, CSR_DATA_W'(phase_counts[phase]));
         write_register(CSR_BUFFER_SIZE, CSR_DATA_W'(phase_sizes[phase]));
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (item == PHASE_ITEMS / 2) begin
               drain();
            end
            random_request();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d requests over %0d buffer and reader settings, %0d replies checked",
               ledger.requests, PHASES + 2, ledger.replies);
      $display("%0d writer queries found the ring full, %0d bytes written in total",
               ledger.full_queries, ledger.byte_total);
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/mrrpm_pkg.sv
rtl/core/mrrpm_wq_unit.sv
rtl/core/multi_reader_ring_pointer_manager.sv
dv/tb_top.sv
